FILE: rtl/scp_ecg_record_parser_defines.svh
// assertion macros for the scp ecg record parser
`ifndef SCP_ECG_RECORD_PARSER_DEFINES_SVH
`define SCP_ECG_RECORD_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk with reset masked
`define SCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/scp_pkg.sv
// shared types and constants of the scp ecg record parser
`default_nettype none
package scp_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_RECORD_CRC  = 3'd1,
    ST_SEC_SHORT   = 3'd2,
    ST_SEC_OVERRUN = 3'd3,
    ST_SEC_CRC     = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [15:0] amplitude;
    logic [15:0] sample_interval;
    logic [15:0] sample_data_length;
    logic [31:0] sample_data_offset;
  } fields_t;

  localparam logic [15:0] CRC_INIT       = 16'hffff;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [7:0]  TAG_END        = 8'hff;
  localparam logic [7:0]  TAG_DATE       = 8'd25;
  localparam logic [7:0]  TAG_TIME       = 8'd26;
  localparam logic [31:0] REC_HDR_LEN    = 32'd6;
  localparam logic [31:0] SEC_HDR_LEN    = 32'd8;
  localparam logic [31:0] SEC_DATA_OFF   = 32'd16;
  localparam logic [31:0] SEC6_MIN_LEN   = 32'd24;
  localparam logic [15:0] SEC_ID_HEADER  = 16'd1;
  localparam logic [15:0] SEC_ID_RHYTHM  = 16'd6;

endpackage
`default_nettype wire

FILE: rtl/scp_ecg_record_parser.sv
// scp ecg record parser top level
//   channel | direction | payload
//   in_     | input     | start_of_record, data_byte
//   out_    | output    | status, date/time fields, section 6 fields
// one byte item is accepted per cycle while in_ready is high; all parsing for it is done in that cycle
// a result is registered on the last record byte and appears on out_ in the next cycle
// in_ready drops only while a result is held and out_ready is low
// rst_n (synchronous) clears all parse state; start_of_record does the same
`default_nettype none
`include "scp_ecg_record_parser_defines.svh"
module scp_ecg_record_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_start_of_record,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [2:0]  out_status,
  output logic      [15:0] out_year,
  output logic      [7:0]  out_month,
  output logic      [7:0]  out_day,
  output logic      [7:0]  out_hour,
  output logic      [7:0]  out_minute,
  output logic      [7:0]  out_second,
  output logic      [15:0] out_amplitude,
  output logic      [15:0] out_sample_interval,
  output logic      [15:0] out_sample_data_length,
  output logic      [31:0] out_sample_data_offset
);
  import scp_pkg::*;

  logic [31:0] pos_r, pos_nxt, rlen_r, rlen_nxt;
  logic [15:0] rcrc_st_r, rcrc_st_nxt, rcrc_r, rcrc_nxt;
  logic [31:0] sstart_r, sstart_nxt, slen_r, slen_nxt;
  logic [15:0] sid_r, sid_nxt, scrc_st_r, scrc_st_nxt, scrc_r, scrc_nxt;
  logic        active_r, active_nxt, done_r, done_nxt;
  status_t     err_r, err_nxt;
  fields_t     staged_r, staged_nxt, commit_r, commit_nxt;
  logic        w_on_r, w_on_nxt;
  logic [1:0]  w_phase_r, w_phase_nxt;
  logic [33:0] w_next_r, w_next_nxt;
  logic [7:0]  w_code_r, w_code_nxt;
  logic [15:0] w_vlen_r, w_vlen_nxt;
  logic        a_on_r, a_on_nxt, a_date_r, a_date_nxt;
  logic [33:0] a_base_r, a_base_nxt;
  logic        d_on_r, d_on_nxt;
  logic [33:0] d_pos_r, d_pos_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, out_status_nxt;
  fields_t     out_fields_r, out_fields_nxt;

  logic        in_fire, res_fire;
  logic [15:0] rcrc_in, rcrc_upd, scrc_in, scrc_upd;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign rcrc_in = in_start_of_record ? CRC_INIT : rcrc_r;
  assign scrc_in = active_r ? scrc_r : CRC_INIT;

  scp_crc16 u_rec_crc (.crc_in(rcrc_in), .data(in_data_byte), .crc_out(rcrc_upd));
  scp_crc16 u_sec_crc (.crc_in(scrc_in), .data(in_data_byte), .crc_out(scrc_upd));

  always_comb begin
    logic [31:0] pos, off, s, last;
    logic [7:0]  b;
    logic [33:0] pos_w, sec_end;
    logic        stop;
    pos_nxt = pos_r; rlen_nxt = rlen_r; rcrc_st_nxt = rcrc_st_r; rcrc_nxt = rcrc_r;
    sstart_nxt = sstart_r; slen_nxt = slen_r; sid_nxt = sid_r;
    scrc_st_nxt = scrc_st_r; scrc_nxt = scrc_r;
    active_nxt = active_r; done_nxt = done_r; err_nxt = err_r;
    staged_nxt = staged_r; commit_nxt = commit_r;
    w_on_nxt = w_on_r; w_phase_nxt = w_phase_r; w_next_nxt = w_next_r;
    w_code_nxt = w_code_r; w_vlen_nxt = w_vlen_r;
    a_on_nxt = a_on_r; a_date_nxt = a_date_r; a_base_nxt = a_base_r;
    d_on_nxt = d_on_r; d_pos_nxt = d_pos_r;
    res_fire = 1'b0;
    pos = '0; off = '0; s = '0; last = '0; pos_w = '0; sec_end = '0; stop = 1'b0;
    b = in_data_byte;
    if (in_fire) begin
      if (in_start_of_record) begin
        pos_nxt = '0; rlen_nxt = '0; rcrc_st_nxt = '0; rcrc_nxt = CRC_INIT;
        sstart_nxt = REC_HDR_LEN; slen_nxt = '0; sid_nxt = '0;
        scrc_st_nxt = '0; scrc_nxt = CRC_INIT;
        active_nxt = 1'b0; done_nxt = 1'b0; err_nxt = ST_OK;
        staged_nxt = '0; commit_nxt = '0;
        w_on_nxt = 1'b1; w_phase_nxt = '0; w_next_nxt = 34'(SEC_DATA_OFF);
        w_code_nxt = '0; w_vlen_nxt = '0;
        a_on_nxt = 1'b0; a_date_nxt = 1'b0; a_base_nxt = '0;
        d_on_nxt = 1'b0; d_pos_nxt = '0;
      end
      if (!done_nxt) begin
        pos = pos_nxt;
        pos_w = {2'b00, pos};
        if (pos < 32'd2) begin
          if (pos[0]) rcrc_st_nxt[15:8] = b;
          else rcrc_st_nxt[7:0] = b;
        end else begin
          rcrc_nxt = rcrc_upd;
        end
        if (pos >= 32'd2 && pos < REC_HDR_LEN) begin
          case (pos[2:0])
            3'd2:    rlen_nxt[7:0]   = b;
            3'd3:    rlen_nxt[15:8]  = b;
            3'd4:    rlen_nxt[23:16] = b;
            default: rlen_nxt[31:24] = b;
          endcase
        end
        // section walk
        if (pos >= REC_HDR_LEN && err_nxt == ST_OK &&
            (active_nxt || pos == sstart_nxt)) begin
          s = sstart_nxt;
          if (!active_nxt) begin
            active_nxt = 1'b1; scrc_st_nxt = '0; sid_nxt = '0; slen_nxt = '0;
            staged_nxt = commit_nxt;
            w_on_nxt = 1'b1; w_phase_nxt = '0;
            w_next_nxt = {2'b00, s} + 34'(SEC_DATA_OFF);
            w_code_nxt = '0; w_vlen_nxt = '0;
            a_on_nxt = 1'b0; a_date_nxt = 1'b0; a_base_nxt = '0;
            d_on_nxt = 1'b0; d_pos_nxt = '0;
          end
          off = pos - s;
          if (off >= 32'd2) scrc_nxt = scrc_upd;
          else scrc_nxt = CRC_INIT;
          if (off < 32'd2) begin
            if (off[0]) scrc_st_nxt[15:8] = b;
            else scrc_st_nxt[7:0] = b;
          end else if (off < 32'd4) begin
            if (off[0]) sid_nxt[15:8] = b;
            else sid_nxt[7:0] = b;
          end else if (off < SEC_HDR_LEN) begin
            case (off[1:0])
              2'd0:    slen_nxt[7:0]   = b;
              2'd1:    slen_nxt[15:8]  = b;
              2'd2:    slen_nxt[23:16] = b;
              default: slen_nxt[31:24] = b;
            endcase
            if (off == 32'd7) begin
              if (slen_nxt < SEC_HDR_LEN) begin
                err_nxt = ST_SEC_SHORT; active_nxt = 1'b0; stop = 1'b1;
              end else if (rlen_nxt >= s && slen_nxt > rlen_nxt - s) begin
                err_nxt = ST_SEC_OVERRUN; active_nxt = 1'b0; stop = 1'b1;
              end
            end
          end else if (off >= SEC_DATA_OFF) begin
            sec_end = {2'b00, s} + {2'b00, slen_nxt};
            if (sid_nxt == SEC_ID_HEADER) begin
              // value captures of the current tag entry
              if (a_on_nxt) begin
                if (pos_w == a_base_nxt + 34'd3) begin
                  if (a_date_nxt) staged_nxt.year[7:0] = b;
                  else staged_nxt.hour = b;
                end else if (pos_w == a_base_nxt + 34'd4) begin
                  if (a_date_nxt) staged_nxt.year[15:8] = b;
                  else staged_nxt.minute = b;
                end else if (pos_w == a_base_nxt + 34'd5) begin
                  if (a_date_nxt) staged_nxt.month = b;
                  else staged_nxt.second = b;
                  a_on_nxt = 1'b0;
                end
              end
              if (d_on_nxt && pos_w == d_pos_nxt) begin
                staged_nxt.day = b;
                d_on_nxt = 1'b0;
              end
              if (w_on_nxt) begin
                case (w_phase_nxt)
                  2'd0: begin
                    if (pos_w == w_next_nxt) begin
                      if (w_next_nxt + 34'd3 > sec_end || b == TAG_END) begin
                        w_on_nxt = 1'b0;
                      end else begin
                        w_code_nxt = b; w_phase_nxt = 2'd1;
                      end
                    end
                  end
                  2'd1: begin
                    w_vlen_nxt = {8'h00, b}; w_phase_nxt = 2'd2;
                  end
                  default: begin
                    w_vlen_nxt[15:8] = b;
                    w_phase_nxt = 2'd0;
                    if ({18'd0, w_vlen_nxt} > sec_end - w_next_nxt) begin
                      w_on_nxt = 1'b0;
                    end else begin
                      if (w_code_nxt == TAG_DATE) begin
                        staged_nxt.year = '0; staged_nxt.month = '0; staged_nxt.day = '0;
                        a_on_nxt = 1'b1; a_date_nxt = 1'b1; a_base_nxt = w_next_nxt;
                        d_on_nxt = 1'b1; d_pos_nxt = w_next_nxt + 34'd6;
                      end else if (w_code_nxt == TAG_TIME) begin
                        staged_nxt.hour = '0; staged_nxt.minute = '0;
                        staged_nxt.second = '0;
                        a_on_nxt = 1'b1; a_date_nxt = 1'b0; a_base_nxt = w_next_nxt;
                      end
                      w_next_nxt = w_next_nxt + 34'd3 + {18'd0, w_vlen_nxt};
                    end
                  end
                endcase
              end
            end else if (sid_nxt == SEC_ID_RHYTHM && slen_nxt >= SEC6_MIN_LEN) begin
              case (off)
                32'd16: begin
                  staged_nxt.amplitude = {8'h00, b};
                  staged_nxt.sample_data_offset = s + SEC6_MIN_LEN;
                end
                32'd17:  staged_nxt.amplitude[15:8] = b;
                32'd18:  staged_nxt.sample_interval = {8'h00, b};
                32'd19:  staged_nxt.sample_interval[15:8] = b;
                32'd22:  staged_nxt.sample_data_length = {8'h00, b};
                32'd23:  staged_nxt.sample_data_length[15:8] = b;
                default: ;
              endcase
            end
          end
          // last byte of the section
          if (!stop && off >= 32'd7 && {1'b0, off} + 33'd1 == {1'b0, slen_nxt}) begin
            if (scrc_nxt == scrc_st_nxt) commit_nxt = staged_nxt;
            else err_nxt = ST_SEC_CRC;
            active_nxt = 1'b0;
            sstart_nxt = s + slen_nxt;
          end
        end
        last = (rlen_nxt > REC_HDR_LEN) ? rlen_nxt - 32'd1 : REC_HDR_LEN - 32'd1;
        if (pos >= REC_HDR_LEN - 32'd1 && pos == last) begin
          res_fire = 1'b1;
          done_nxt = 1'b1;
        end else begin
          pos_nxt = pos + 32'd1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_fields_nxt = out_fields_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (res_fire) begin
      out_valid_nxt = 1'b1;
      if (rcrc_nxt != rcrc_st_nxt) begin
        out_status_nxt = ST_RECORD_CRC;
        out_fields_nxt = '0;
      end else begin
        out_fields_nxt = commit_nxt;
        if (err_nxt != ST_OK) out_status_nxt = err_nxt;
        else if (active_nxt) out_status_nxt = ST_SEC_OVERRUN;
        else out_status_nxt = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; rlen_r <= '0; rcrc_st_r <= '0; rcrc_r <= CRC_INIT;
      sstart_r <= REC_HDR_LEN; slen_r <= '0; sid_r <= '0;
      scrc_st_r <= '0; scrc_r <= CRC_INIT;
      active_r <= 1'b0; done_r <= 1'b0; err_r <= ST_OK;
      staged_r <= '0; commit_r <= '0;
      w_on_r <= 1'b1; w_phase_r <= '0; w_next_r <= 34'(SEC_DATA_OFF);
      w_code_r <= '0; w_vlen_r <= '0;
      a_on_r <= 1'b0; a_date_r <= 1'b0; a_base_r <= '0;
      d_on_r <= 1'b0; d_pos_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt; rlen_r <= rlen_nxt; rcrc_st_r <= rcrc_st_nxt; rcrc_r <= rcrc_nxt;
      sstart_r <= sstart_nxt; slen_r <= slen_nxt; sid_r <= sid_nxt;
      scrc_st_r <= scrc_st_nxt; scrc_r <= scrc_nxt;
      active_r <= active_nxt; done_r <= done_nxt; err_r <= err_nxt;
      staged_r <= staged_nxt; commit_r <= commit_nxt;
      w_on_r <= w_on_nxt; w_phase_r <= w_phase_nxt; w_next_r <= w_next_nxt;
      w_code_r <= w_code_nxt; w_vlen_r <= w_vlen_nxt;
      a_on_r <= a_on_nxt; a_date_r <= a_date_nxt; a_base_r <= a_base_nxt;
      d_on_r <= d_on_nxt; d_pos_r <= d_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_fields_r <= out_fields_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_year               = out_fields_r.year;
  assign out_month              = out_fields_r.month;
  assign out_day                = out_fields_r.day;
  assign out_hour               = out_fields_r.hour;
  assign out_minute             = out_fields_r.minute;
  assign out_second             = out_fields_r.second;
  assign out_amplitude          = out_fields_r.amplitude;
  assign out_sample_interval    = out_fields_r.sample_interval;
  assign out_sample_data_length = out_fields_r.sample_data_length;
  assign out_sample_data_offset = out_fields_r.sample_data_offset;

  `SCP_ASSERT_NEXT(a_done_after_result, res_fire, done_r && out_valid_r, "result without done")
  `SCP_ASSERT_NOW(a_crc_fail_zero, out_valid_r && out_status_r == ST_RECORD_CRC,
    out_fields_r == '0, "record crc failure with nonzero fields")
  `SCP_ASSERT_NOW(a_err_idle, err_r != ST_OK, !active_r, "section active after error")

endmodule
`default_nettype wire

FILE: rtl/scp_crc16.sv
// crc-ccitt update by one byte, msb first
`default_nettype none
module scp_crc16 (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc_out
);
  import scp_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    crc_out = c;
  end

endmodule
`default_nettype wire
